[rtl/core/mmcs_pkg.sv]
// Shared types and constants for the min/max contrast stretch block.
// No dependencies; used by every module in rtl/core.
package mmcs_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned LVL_W       = 8;
  localparam int unsigned NUM_W       = 2 * LVL_W;

  localparam logic [LVL_W-1:0] LVL_MIN_RST = 8'd255;
  localparam logic [LVL_W-1:0] LVL_MAX_RST = 8'd0;
  localparam logic [LVL_W-1:0] LVL_FULL    = 8'd255;
  localparam logic [LVL_W-1:0] LVL_ZERO    = 8'd0;

  typedef enum logic {
    OP_MEASURE = 1'b0,
    OP_MAP     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_SAT  = 2'd2,
    KIND_DIV  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } bk_state_e;

  typedef struct packed {
    kind_e             kind;
    logic [PIX_W-1:0]  pixel;
    logic [NUM_W-1:0]  num;
    logic [LVL_W-1:0]  den;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/core/mmcs_front.sv]
// Front end: accepts items, tracks running min/max, classifies map items.
// Depends on mmcs_pkg.
module mmcs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_op_i,
  input  logic                        in_start_i,
  input  logic [mmcs_pkg::PIX_W-1:0]  in_pixel_i,
  output logic                        in_ready_o,
  input  mmcs_pkg::q_status_t         q_status_i,
  output logic                        q_push_o,
  output mmcs_pkg::entry_t            q_entry_o
);

  logic [mmcs_pkg::LVL_W-1:0] min_q, min_d, max_q, max_d;
  logic [mmcs_pkg::LVL_W-1:0] level, diff, den;
  logic                       accept, is_map;

  assign level      = in_pixel_i[mmcs_pkg::LVL_W-1:0];
  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign is_map     = (mmcs_pkg::op_e'(in_op_i) == mmcs_pkg::OP_MAP);
  assign q_push_o   = accept && is_map;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (accept && !is_map) begin
      if (in_start_i) begin
        min_d = level;
        max_d = level;
      end else begin
        if (level < min_q) min_d = level;
        if (level > max_q) max_d = level;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= mmcs_pkg::LVL_MIN_RST;
      max_q <= mmcs_pkg::LVL_MAX_RST;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign diff = level - min_q;
  assign den  = max_q - min_q;

  // num = diff * 255
  always_comb begin
    q_entry_o.pixel = in_pixel_i;
    q_entry_o.den   = den;
    q_entry_o.num   = {diff, {mmcs_pkg::LVL_W{1'b0}}} - {{mmcs_pkg::LVL_W{1'b0}}, diff};
    priority if (max_q <= min_q) begin
      q_entry_o.kind = mmcs_pkg::KIND_PASS;
    end else if (level <= min_q) begin
      q_entry_o.kind = mmcs_pkg::KIND_ZERO;
    end else if (level >= max_q) begin
      q_entry_o.kind = mmcs_pkg::KIND_SAT;
    end else begin
      q_entry_o.kind = mmcs_pkg::KIND_DIV;
    end
  end

endmodule

[rtl/core/mmcs_queue.sv]
// Short FIFO of classified map items between front and back.
// Depends on mmcs_pkg.
module mmcs_queue #(
  parameter int unsigned Depth = mmcs_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mmcs_pkg::entry_t     entry_i,
  input  logic                 pop_i,
  output mmcs_pkg::entry_t     entry_o,
  output mmcs_pkg::q_status_t  status_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  mmcs_pkg::entry_t mem_q [Depth];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign entry_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!status_o.full || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue pop while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue count out of range");

endmodule

[rtl/core/mmcs_back.sv]
// Back end: bit-serial restoring divider and output register.
// Depends on mmcs_pkg.
module mmcs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mmcs_pkg::q_status_t         q_status_i,
  input  mmcs_pkg::entry_t            q_entry_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mmcs_pkg::PIX_W-1:0]  out_pixel_o
);

  localparam int unsigned LW = mmcs_pkg::LVL_W;
  localparam int unsigned SW = $clog2(LW);

  mmcs_pkg::bk_state_e        st_q, st_d;
  mmcs_pkg::entry_t           ent_q;
  logic [LW-1:0]              rem_q, lo_q, byte_v;
  logic [SW-1:0]              cnt_q;
  logic [LW:0]                trial;
  logic                       out_vld_q, out_free, load_out, step;
  logic [mmcs_pkg::PIX_W-1:0] out_q, res;

  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      mmcs_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          st_d = (q_entry_i.kind == mmcs_pkg::KIND_DIV) ? mmcs_pkg::BK_DIV
                                                         : mmcs_pkg::BK_DONE;
        end
      end
      mmcs_pkg::BK_DIV:  if (cnt_q == '0) st_d = mmcs_pkg::BK_DONE;
      mmcs_pkg::BK_DONE: if (out_free) st_d = mmcs_pkg::BK_IDLE;
      default:           st_d = mmcs_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = (st_q == mmcs_pkg::BK_IDLE) && !q_status_i.empty;
    step     = (st_q == mmcs_pkg::BK_DIV);
    load_out = (st_q == mmcs_pkg::BK_DONE) && out_free;
  end

  assign trial = {rem_q, lo_q[LW-1]};

  always_comb begin
    unique case (ent_q.kind)
      mmcs_pkg::KIND_ZERO: byte_v = mmcs_pkg::LVL_ZERO;
      mmcs_pkg::KIND_SAT:  byte_v = mmcs_pkg::LVL_FULL;
      default:             byte_v = lo_q;
    endcase
    if (ent_q.kind == mmcs_pkg::KIND_PASS) res = ent_q.pixel;
    else res = {ent_q.pixel[mmcs_pkg::PIX_W-1 -: LW], byte_v, byte_v, byte_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= mmcs_pkg::BK_IDLE;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      st_q <= st_d;
      if (load_out) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      if (q_pop_o) cnt_q <= SW'(LW - 1);
      else if (step) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_entry_i;
      rem_q <= q_entry_i.num[2*LW-1:LW];
      lo_q  <= q_entry_i.num[LW-1:0];
    end else if (step) begin
      if (trial >= {1'b0, ent_q.den}) begin
        rem_q <= LW'(trial - {1'b0, ent_q.den});
        lo_q  <= {lo_q[LW-2:0], 1'b1};
      end else begin
        rem_q <= trial[LW-1:0];
        lo_q  <= {lo_q[LW-2:0], 1'b0};
      end
    end
    if (load_out) out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_pixel_o = out_q;

  a_div_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mmcs_pkg::BK_DIV) |-> (ent_q.den != '0))
    else $error("divide with zero range");

  a_div_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == mmcs_pkg::BK_DIV) |=>
      (st_q == mmcs_pkg::BK_DIV || st_q == mmcs_pkg::BK_DONE))
    else $error("divider left early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_pixel_o)))
    else $error("output item changed while stalled");

endmodule

[rtl/core/min_max_contrast_stretch.sv]
// Top level of the min/max contrast stretch: front, queue, back.
// Depends on mmcs_pkg, mmcs_front, mmcs_queue, mmcs_back.
//
// channel  dir  tdata            tuser
// s_axis   in   [31:0] pixel_in  [0] opcode, [1] frame_start
// m_axis   out  [31:0] pixel_out -
//
// Measure items take one cycle each while the queue has room.
// A map item in the back end: load from the queue, eight divider steps
// (one quotient bit each), then the output register is filled when free.
// Saturated, zero and flat-range items skip the divider.
// Reset clears min to 255, max to 0, the queue and the output valid.
// A stalled m_axis holds the back end; the queue lets the front keep going.
module min_max_contrast_stretch #(
  parameter int unsigned QueueDepth = mmcs_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] pixel_in
  input  logic [1:0]  s_axis_tuser,   // [0] opcode, [1] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] pixel_out
);

  mmcs_pkg::q_status_t q_status;
  mmcs_pkg::entry_t    push_entry, pop_entry;
  logic                push, pop;

  mmcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser[0]),
    .in_start_i (s_axis_tuser[1]),
    .in_pixel_i (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .q_status_i (q_status),
    .q_push_o   (push),
    .q_entry_o  (push_entry)
  );

  mmcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  mmcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_entry_i   (pop_entry),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pixel_o (m_axis_tdata)
  );

endmodule

[bench/mmcs_checker.sv]
`timescale 1ns / 1ps
// Checker for min_max_contrast_stretch: watches both stream channels, tracks
// the measured min/max levels and compares every stretched pixel in order.
// Depends on mmcs_pkg.
module mmcs_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] pixel_in
  input  logic [1:0]  s_axis_tuser,   // [0] opcode, [1] frame_start
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] pixel_out
  output int          fail_count_o,
  output int          pending_o,
  output int          n_measure_o,
  output int          n_map_o,
  output int          n_saturated_o,
  output int          n_divided_o
);

  localparam int unsigned PW = mmcs_pkg::PIX_W;
  localparam int unsigned LW = mmcs_pkg::LVL_W;
  localparam int unsigned NW = mmcs_pkg::NUM_W;

  logic [LW-1:0] lvl_lo;
  logic [LW-1:0] lvl_hi;
  logic [PW-1:0] stretched_q[$];

  function automatic logic [PW-1:0] stretch_pixel(
    input  logic [PW-1:0]   pix,
    input  logic [LW-1:0]   lo,
    input  logic [LW-1:0]   hi,
    output mmcs_pkg::kind_e kind
  );
    logic [LW-1:0] lvl;
    logic [LW-1:0] s;
    logic [NW-1:0] num;
    lvl = pix[LW-1:0];
    s = mmcs_pkg::LVL_ZERO;
    if (hi <= lo) begin
      kind = mmcs_pkg::KIND_PASS;
      return pix;
    end
    if (lvl <= lo) begin
      kind = mmcs_pkg::KIND_ZERO;
      s = mmcs_pkg::LVL_ZERO;
    end else if (lvl >= hi) begin
      kind = mmcs_pkg::KIND_SAT;
      s = mmcs_pkg::LVL_FULL;
    end else begin
      kind = mmcs_pkg::KIND_DIV;
      num = NW'(lvl - lo) * NW'(mmcs_pkg::LVL_FULL);
      s = LW'(num / NW'(hi - lo));
    end
    return {pix[PW-1:PW-LW], s, s, s};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [PW-1:0]   want;
    logic [LW-1:0]   lvl;
    mmcs_pkg::kind_e kind;
    if (!rst_ni) begin
      lvl_lo = mmcs_pkg::LVL_MIN_RST;
      lvl_hi = mmcs_pkg::LVL_MAX_RST;
      stretched_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      n_measure_o   = 0;
      n_map_o       = 0;
      n_saturated_o = 0;
      n_divided_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (stretched_q.size() == 0) begin
          $error("pixel_out: no result expected, got %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = stretched_q.pop_front();
          if (m_axis_tdata !== want) begin
            $error("pixel_out mismatch: expected %h, actual %h", want, m_axis_tdata);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        lvl = s_axis_tdata[LW-1:0];
        if (mmcs_pkg::op_e'(s_axis_tuser[0]) == mmcs_pkg::OP_MEASURE) begin
          n_measure_o++;
          if (s_axis_tuser[1]) begin
            lvl_lo = lvl;
            lvl_hi = lvl;
          end else begin
            if (lvl < lvl_lo) lvl_lo = lvl;
            if (lvl > lvl_hi) lvl_hi = lvl;
          end
        end else begin
          n_map_o++;
          stretched_q.push_back(stretch_pixel(s_axis_tdata, lvl_lo, lvl_hi, kind));
          if (kind == mmcs_pkg::KIND_ZERO || kind == mmcs_pkg::KIND_SAT) n_saturated_o++;
          if (kind == mmcs_pkg::KIND_DIV) n_divided_o++;
        end
      end
      pending_o = stretched_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for min_max_contrast_stretch: clock, reset, stimulus,
// output back-pressure and verdict. Depends on mmcs_pkg and mmcs_checker.
module tb_top;

  localparam int N_ITEMS     = 1500;
  localparam int CALM_FROM   = 300;
  localparam int CALM_TO     = 600;
  localparam int HOLD_AT     = 900;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN       = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] pixel_in
  logic [1:0]  s_axis_tuser = '0;   // [0] opcode, [1] frame_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] pixel_out

  int fail_count;
  int pending;
  int n_measure;
  int n_map;
  int n_saturated;
  int n_divided;
  int items_sent = 0;
  bit calm = 1'b0;
  int stall_cycles = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  min_max_contrast_stretch DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mmcs_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .n_measure_o   (n_measure),
    .n_map_o       (n_map),
    .n_saturated_o (n_saturated),
    .n_divided_o   (n_divided)
  );

  task automatic send_item(input mmcs_pkg::op_e op, input logic fs,
                           input logic [mmcs_pkg::PIX_W-1:0] pix);
    if (!calm && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= {fs, op};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
  endtask

  // output back-pressure, with one long hold-off to fill the block
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && items_sent >= HOLD_AT) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      m_axis_tready <= rst_ni && (calm || $urandom_range(99) >= 16);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item accepted for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int n_meas;
    int n_map_run;
    logic [mmcs_pkg::PIX_W-1:0] pix;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state: unmeasured range passes pixels unchanged
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'hA5C3_7E10);
    send_item(mmcs_pkg::OP_MAP, 1'b1, 32'h0000_00FF);
    // measure without frame start from reset collapses to one level
    send_item(mmcs_pkg::OP_MEASURE, 1'b0, 32'h1234_5680);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'hFFFF_FF00);
    // range 0x20..0xE0: below, at min, at max, above, inside
    send_item(mmcs_pkg::OP_MEASURE, 1'b1, 32'hDEAD_BE20);
    send_item(mmcs_pkg::OP_MEASURE, 1'b0, 32'h0000_00E0);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'hFFFF_FF00);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'h8000_0020);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'h7F00_00E0);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'h0155_AAFF);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'hFFFF_FF21);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'h0000_00DF);
    // frame start on a map leaves min and max alone
    send_item(mmcs_pkg::OP_MAP, 1'b1, 32'h5A5A_5A80);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'hA5A5_A580);
    // full range
    send_item(mmcs_pkg::OP_MEASURE, 1'b1, 32'h0000_0000);
    send_item(mmcs_pkg::OP_MEASURE, 1'b0, 32'hFFFF_FFFF);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'hC3C3_C301);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'h3C3C_3CFE);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'hFFFF_FF7F);
    // flat frame
    send_item(mmcs_pkg::OP_MEASURE, 1'b1, 32'h0000_0033);
    send_item(mmcs_pkg::OP_MEASURE, 1'b0, 32'hFFFF_FF33);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'h1111_1190);
    // one-step range
    send_item(mmcs_pkg::OP_MEASURE, 1'b1, 32'h0000_0064);
    send_item(mmcs_pkg::OP_MEASURE, 1'b0, 32'h0000_0065);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'hEEEE_EE64);
    send_item(mmcs_pkg::OP_MAP, 1'b0, 32'h2222_2265);

    while (items_sent < N_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        n_meas = $urandom_range(1, 12);
        for (int i = 0; i < n_meas; i++) begin
          pix = $urandom;
          if ($urandom_range(9) == 0) begin
            pix[mmcs_pkg::LVL_W-1:0] = $urandom_range(1) ? mmcs_pkg::LVL_FULL
                                                          : mmcs_pkg::LVL_ZERO;
          end
          send_item(mmcs_pkg::OP_MEASURE, i == 0, pix);
        end
        n_map_run = $urandom_range(1, 20);
        for (int i = 0; i < n_map_run; i++) begin
          send_item(mmcs_pkg::OP_MAP, $urandom_range(9) == 0, $urandom);
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_item(mmcs_pkg::op_e'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Run covered %0d measure and %0d map items, including frame restarts,",
             n_measure, n_map);
    $display("flat ranges, %0d saturated and %0d divided levels.", n_saturated, n_divided);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/mmcs_pkg.sv
rtl/core/mmcs_front.sv
rtl/core/mmcs_queue.sv
rtl/core/mmcs_back.sv
rtl/core/min_max_contrast_stretch.sv
bench/mmcs_checker.sv
bench/tb_top.sv
